// ===== rtl/mm3_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared types, constants and helpers for the 128-bit murmur3 hash block.
// ----------------------------------------------------------------------------
package mm3_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned COUNT_W   = 5;
    localparam int unsigned BLOCK_B   = 16;
    localparam int unsigned S_TDATA_W = 136;  // 133 payload bits padded to bytes
    localparam int unsigned M_TDATA_W = 136;

    localparam logic [COUNT_W-1:0] FULL_COUNT    = 5'd16;
    localparam logic [COUNT_W-1:0] DIGEST_RESET  = 5'd16;

    localparam logic [WORD_W-1:0] MM_C1 = 64'h87c37b91114253d5;
    localparam logic [WORD_W-1:0] MM_C2 = 64'h4cf5ad432745937f;
    localparam logic [WORD_W-1:0] MM_N1 = 64'h0000000052dce729;
    localparam logic [WORD_W-1:0] MM_N2 = 64'h0000000038495ab5;
    localparam logic [WORD_W-1:0] MM_F1 = 64'hff51afd7ed558ccd;
    localparam logic [WORD_W-1:0] MM_F2 = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCR1,
        ST_SCR1_W,
        ST_SCR2,
        ST_SCR2_W,
        ST_MIX1A,
        ST_MIX1B,
        ST_MIX2A,
        ST_MIX2B,
        ST_TAIL,
        ST_LEN,
        ST_ADD1,
        ST_ADD2,
        ST_FM1,
        ST_FM1_W,
        ST_FM2,
        ST_FM2_W,
        ST_FMX,
        ST_ADD3,
        ST_ADD4,
        ST_OUT
    } state_t;

    // operand / constant selection for the two multiplier lanes
    typedef enum logic [1:0] {
        MS_IN,   // block words by C1 / C2
        MS_ROT,  // rotated first products by C2 / C1
        MS_FM1,  // fmix first step by F1
        MS_FM2   // fmix second step by F2
    } mul_src_t;

    // updates of the running hash words
    typedef enum logic [3:0] {
        H_NONE,
        H_MIX1A,  // h1 = rotl(h1 ^ k1, 27) + h2
        H_MIX1B,  // h1 = h1 * 5 + N1
        H_MIX2A,  // h2 = rotl(h2 ^ k2, 31) + h1
        H_MIX2B,  // h2 = h2 * 5 + N2
        H_TAIL,   // h1 ^= k1, h2 ^= k2
        H_XTOT,   // h1 ^= total, h2 ^= total
        H_ADD1,   // h1 += h2
        H_ADD2,   // h2 += h1
        H_FMIX,   // h = p ^ (p >> 33)
        H_CLEAR
    } h_op_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_src_t mul_src;
        h_op_t    h_op;
        logic     out_load;
    } mm3_cmd_t;

    typedef struct packed {
        logic last;      // block in flight is the final one
        logic full;      // block in flight holds 16 bytes
        logic out_free;  // output register can take a result this cycle
    } mm3_status_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                 input int unsigned s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    // ones in the low n bytes of a 16-byte block, n in 0..16
    function automatic logic [2*WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] n);
        logic [2*WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < BLOCK_B; i++) begin
            m[8*i +: 8] = (COUNT_W'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mm3_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_mul
// 64x64 multiplier keeping the low 64 bits, built from three 32x32 partial
// products. Two register stages; both advance only while en is high.
// ----------------------------------------------------------------------------
module mm3_mul (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [63:0] a,
    input  wire logic [63:0] c,
    output logic      [63:0] p
);
    import mm3_pkg::*;

    logic [63:0] m_ll;
    logic [63:0] m_lh;
    logic [63:0] m_hl;
    logic [63:0] pp_ll_reg;
    logic [31:0] pp_lh_reg;
    logic [31:0] pp_hl_reg;
    logic [31:0] mid_sum;
    logic [63:0] p_reg;

    always_comb begin
        m_ll    = 64'(a[31:0]) * 64'(c[31:0]);
        m_lh    = 64'(a[31:0]) * 64'(c[63:32]);
        m_hl    = 64'(a[63:32]) * 64'(c[31:0]);
        mid_sum = pp_lh_reg + pp_hl_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_ll_reg <= m_ll;
            pp_lh_reg <= m_lh[31:0];
            pp_hl_reg <= m_hl[31:0];
            p_reg     <= pp_ll_reg + {mid_sum, 32'h0};
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== rtl/mm3_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_dp
// Datapath: block capture and tail masking, two multiplier lanes, running
// hash words, length counter, digest setting and the output register.
// ----------------------------------------------------------------------------
module mm3_dp (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mm3_pkg::mm3_cmd_t    cmd,
    output mm3_pkg::mm3_status_t      st,
    input  wire logic [63:0]          s_word_lo,
    input  wire logic [63:0]          s_word_hi,
    input  wire logic [4:0]           s_byte_count,
    input  wire logic                 s_last,
    input  wire logic                 cfg_we,
    input  wire logic [4:0]           cfg_digest_bytes,
    input  wire logic                 m_tready,
    output logic                      m_valid,
    output logic [63:0]               m_hash_lo,
    output logic [63:0]               m_hash_hi,
    output logic [4:0]                m_digest_len
);
    import mm3_pkg::*;

    logic [WORD_W-1:0]   lo_reg;
    logic [WORD_W-1:0]   hi_reg;
    logic                last_reg;
    logic                full_reg;
    logic [WORD_W-1:0]   h1_reg, h1_next;
    logic [WORD_W-1:0]   h2_reg, h2_next;
    logic [WORD_W-1:0]   tot_reg;
    logic [COUNT_W-1:0]  digest_reg;
    logic                m_valid_reg;
    logic [WORD_W-1:0]   hash_lo_reg;
    logic [WORD_W-1:0]   hash_hi_reg;
    logic [COUNT_W-1:0]  digest_len_reg;

    logic [COUNT_W-1:0]  cnt_eff;
    logic [2*WORD_W-1:0] in_mask;
    logic [COUNT_W-1:0]  keep;
    logic [2*WORD_W-1:0] out_mask;
    logic [WORD_W-1:0]   op_a, op_b, c_a, c_b;
    logic [WORD_W-1:0]   pa, pb;
    logic [WORD_W-1:0]   t1, t2;

    // non-last blocks always count as 16 bytes; counts above 16 saturate
    always_comb begin
        if (!s_last || s_byte_count > FULL_COUNT) begin
            cnt_eff = FULL_COUNT;
        end else begin
            cnt_eff = s_byte_count;
        end
        in_mask  = byte_mask(cnt_eff);
        keep     = (digest_reg > FULL_COUNT) ? FULL_COUNT : digest_reg;
        out_mask = byte_mask(keep);
    end

    // multiplier operand selection
    always_comb begin
        case (cmd.mul_src)
            MS_IN: begin
                op_a = lo_reg;
                op_b = hi_reg;
                c_a  = MM_C1;
                c_b  = MM_C2;
            end
            MS_ROT: begin
                op_a = rotl64(pa, 31);
                op_b = rotl64(pb, 33);
                c_a  = MM_C2;
                c_b  = MM_C1;
            end
            MS_FM1: begin
                op_a = h1_reg ^ (h1_reg >> 33);
                op_b = h2_reg ^ (h2_reg >> 33);
                c_a  = MM_F1;
                c_b  = MM_F1;
            end
            default: begin
                op_a = pa ^ (pa >> 33);
                op_b = pb ^ (pb >> 33);
                c_a  = MM_F2;
                c_b  = MM_F2;
            end
        endcase
    end

    mm3_mul u_mul_a (
        .aclk (aclk),
        .en   (cmd.mul_en),
        .a    (op_a),
        .c    (c_a),
        .p    (pa)
    );

    mm3_mul u_mul_b (
        .aclk (aclk),
        .en   (cmd.mul_en),
        .a    (op_b),
        .c    (c_b),
        .p    (pb)
    );

    always_comb begin
        h1_next = h1_reg;
        h2_next = h2_reg;
        t1      = rotl64(h1_reg ^ pa, 27);
        t2      = rotl64(h2_reg ^ pb, 31);
        case (cmd.h_op)
            H_MIX1A: h1_next = t1 + h2_reg;
            H_MIX1B: h1_next = (h1_reg << 2) + h1_reg + MM_N1;
            H_MIX2A: h2_next = t2 + h1_reg;
            H_MIX2B: h2_next = (h2_reg << 2) + h2_reg + MM_N2;
            H_TAIL: begin
                h1_next = h1_reg ^ pa;
                h2_next = h2_reg ^ pb;
            end
            H_XTOT: begin
                h1_next = h1_reg ^ tot_reg;
                h2_next = h2_reg ^ tot_reg;
            end
            H_ADD1:  h1_next = h1_reg + h2_reg;
            H_ADD2:  h2_next = h2_reg + h1_reg;
            H_FMIX: begin
                h1_next = pa ^ (pa >> 33);
                h2_next = pb ^ (pb >> 33);
            end
            H_CLEAR: begin
                h1_next = '0;
                h2_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_reg      <= '0;
            h2_reg      <= '0;
            tot_reg     <= '0;
            digest_reg  <= DIGEST_RESET;
            m_valid_reg <= 1'b0;
            last_reg    <= 1'b0;
            full_reg    <= 1'b0;
        end else begin
            h1_reg <= h1_next;
            h2_reg <= h2_next;
            if (cmd.h_op == H_CLEAR) begin
                tot_reg <= '0;
            end else if (cmd.load_in) begin
                tot_reg <= tot_reg + WORD_W'(cnt_eff);
            end
            if (cmd.load_in) begin
                last_reg <= s_last;
                full_reg <= (cnt_eff == FULL_COUNT);
            end
            if (cfg_we) begin
                digest_reg <= cfg_digest_bytes;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            lo_reg <= s_word_lo & in_mask[WORD_W-1:0];
            hi_reg <= s_word_hi & in_mask[2*WORD_W-1:WORD_W];
        end
        if (cmd.out_load) begin
            hash_lo_reg    <= h1_reg & out_mask[WORD_W-1:0];
            hash_hi_reg    <= h2_reg & out_mask[2*WORD_W-1:WORD_W];
            digest_len_reg <= keep;
        end
    end

    always_comb begin
        st.last     = last_reg;
        st.full     = full_reg;
        st.out_free = !m_valid_reg || m_tready;
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_lo    = hash_lo_reg;
    assign m_hash_hi    = hash_hi_reg;
    assign m_digest_len = digest_len_reg;

    a_clear_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.h_op == H_CLEAR |=> h1_reg == '0 && h2_reg == '0 && tot_reg == '0)
        else $error("hash state not cleared after result");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in && !s_last |=> tot_reg == $past(tot_reg) + 64'd16)
        else $error("non-last word not counted as 16 bytes");

    a_digest_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg && (hash_hi_reg == '0 || digest_len_reg > 5'd8))
        else $error("upper hash word not masked");

endmodule
`default_nettype wire

// ===== rtl/mm3_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm3_ctrl
// Sequencer: steps each 16-byte word through scramble and mix or tail, and the
// last word through finalization; hands the digest to the output register.
// ----------------------------------------------------------------------------
module mm3_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire mm3_pkg::mm3_status_t st,
    output logic                      s_tready,
    output mm3_pkg::mm3_cmd_t         cmd
);
    import mm3_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.mul_en   = 1'b0;
        cmd.mul_src  = MS_IN;
        cmd.h_op     = H_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_SCR1;
                end
            end
            ST_SCR1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_IN;
                state_next  = ST_SCR1_W;
            end
            ST_SCR1_W: begin
                cmd.mul_en = 1'b1;
                state_next = ST_SCR2;
            end
            ST_SCR2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_ROT;
                state_next  = ST_SCR2_W;
            end
            ST_SCR2_W: begin
                cmd.mul_en = 1'b1;
                // partial last word is xored in as the tail, never mixed
                state_next = (st.last && !st.full) ? ST_TAIL : ST_MIX1A;
            end
            ST_MIX1A: begin
                cmd.h_op   = H_MIX1A;
                state_next = ST_MIX1B;
            end
            ST_MIX1B: begin
                cmd.h_op   = H_MIX1B;
                state_next = ST_MIX2A;
            end
            ST_MIX2A: begin
                cmd.h_op   = H_MIX2A;
                state_next = ST_MIX2B;
            end
            ST_MIX2B: begin
                cmd.h_op   = H_MIX2B;
                state_next = st.last ? ST_LEN : ST_IDLE;
            end
            ST_TAIL: begin
                cmd.h_op   = H_TAIL;
                state_next = ST_LEN;
            end
            ST_LEN: begin
                cmd.h_op   = H_XTOT;
                state_next = ST_ADD1;
            end
            ST_ADD1: begin
                cmd.h_op   = H_ADD1;
                state_next = ST_ADD2;
            end
            ST_ADD2: begin
                cmd.h_op   = H_ADD2;
                state_next = ST_FM1;
            end
            ST_FM1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_FM1;
                state_next  = ST_FM1_W;
            end
            ST_FM1_W: begin
                cmd.mul_en = 1'b1;
                state_next = ST_FM2;
            end
            ST_FM2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_FM2;
                state_next  = ST_FM2_W;
            end
            ST_FM2_W: begin
                cmd.mul_en = 1'b1;
                state_next = ST_FMX;
            end
            ST_FMX: begin
                cmd.h_op   = H_FMIX;
                state_next = ST_ADD3;
            end
            ST_ADD3: begin
                cmd.h_op   = H_ADD1;
                state_next = ST_ADD4;
            end
            ST_ADD4: begin
                cmd.h_op   = H_ADD2;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.h_op     = H_CLEAR;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE && s_tvalid |=> state_reg == ST_SCR1)
        else $error("accepted word did not start scrambling");

    a_full_mixed: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCR2_W && !st.last |=> state_reg == ST_MIX1A)
        else $error("non-last word skipped the mix");

    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MIX2B && !st.last |=> state_reg == ST_IDLE && s_tready)
        else $error("non-last word entered finalization");

endmodule
`default_nettype wire

// ===== rtl/murmur3_128_hash.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// murmur3_128_hash
// 128-bit murmur3 (x64 variant, seed zero) over a stream of 16-byte words.
// ----------------------------------------------------------------------------
// Input words arrive on the s_ stream: two little-endian 64-bit message words
// and a byte count in s_tdata, s_tlast on the final word of a message. Only the
// final word may be partial; an empty message is one last word of zero bytes.
// The digest leaves on the m_ stream, one word per message. cfg_data sets how
// many digest bytes are kept (reset 16); write it only while the block is idle.
// s_tready drops after each accepted word, so a new word is taken only once the
// previous one is through: the two constant multiplies of the scramble run in
// the three-partial-product multipliers, followed by the serial h1/h2 mix. A
// last word then runs length mixing and fmix before its digest is loaded into
// the output register; a partial or empty last word is xored in as the tail
// instead of mixed.
// The output register holds the digest while m_tready is low; the next
// message's words are still taken, and only the following digest waits.
// Reset clears the hash state, the byte total and the output valid, and sets
// the digest length back to 16.
// ----------------------------------------------------------------------------
module murmur3_128_hash (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // word_lo[63:0], word_hi[127:64], byte_count[132:128], zero pad
    input  wire logic [mm3_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // hash_lo[63:0], hash_hi[127:64], digest_len[132:128], zero pad
    output logic      [mm3_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mm3_pkg::COUNT_W-1:0]     cfg_data
);
    import mm3_pkg::*;

    mm3_cmd_t    cmd;
    mm3_status_t st;
    logic [WORD_W-1:0]  hash_lo;
    logic [WORD_W-1:0]  hash_hi;
    logic [COUNT_W-1:0] digest_len;

    assign cfg_ready = 1'b1;

    mm3_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .st       (st),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    mm3_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .st               (st),
        .s_word_lo        (s_tdata[63:0]),
        .s_word_hi        (s_tdata[127:64]),
        .s_byte_count     (s_tdata[132:128]),
        .s_last           (s_tlast),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_digest_bytes (cfg_data),
        .m_tready         (m_tready),
        .m_valid          (m_tvalid),
        .m_hash_lo        (hash_lo),
        .m_hash_hi        (hash_hi),
        .m_digest_len     (digest_len)
    );

    assign m_tdata = {3'b000, digest_len, hash_hi, hash_lo};

endmodule
`default_nettype wire
